@@ rtl/core/marf_pkg.sv @@
// Shared types, codes and constants of the mesh ack/retry forwarder.
// Used by marf_engine, marf_out_fifo and mesh_ack_retry_forwarder; no dependencies.
`default_nettype none

package marf_pkg;

	// Field widths of the packet header, the request code, the timer and the configuration channel.
	localparam int ID_W   = 32;
	localparam int NODE_W = 8;
	localparam int TTL_W  = 8;
	localparam int HOPS_W = 8;
	localparam int REQ_W  = 2;
	localparam int TIME_W = 32;
	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 32;

	// Packed stream widths: header fields on tdata, selectors on tuser.
	localparam int IN_TDATA_W  = 56;
	localparam int IN_TUSER_W  = 3;
	localparam int OUT_TDATA_W = 56;
	localparam int OUT_TUSER_W = 4;

	// Default depth of the result queue (a power of two, at least 2).
	localparam int FIFO_DEPTH_DEF = 4;

	// Request codes.
	localparam logic [REQ_W-1:0] REQ_SEND = 2'd0;
	localparam logic [REQ_W-1:0] REQ_RX   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_TICK = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_NODE_ID     = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_TTL = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_RETRY   = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_ACK_TIMEOUT = 8'd3;

	// Register reset values.
	localparam logic [NODE_W-1:0] NODE_ID_RST     = 8'd0;
	localparam logic [TTL_W-1:0]  DEFAULT_TTL_RST = 8'd3;
	localparam logic [7:0]        MAX_RETRY_RST   = 8'd3;
	localparam logic [TIME_W-1:0] ACK_TIMEOUT_RST = 32'd2000;

	// TTL placed in every ack packet.
	localparam logic [TTL_W-1:0] ACK_TTL = 8'd1;

	// Result kinds.
	typedef enum logic [2:0] {
		KIND_NEW     = 3'd0,
		KIND_ACK     = 3'd1,
		KIND_FWD     = 3'd2,
		KIND_RETRY   = 3'd3,
		KIND_MATCHED = 3'd4,
		KIND_FAILED  = 3'd5,
		KIND_DROP    = 3'd6
	} kind_t;

	// One input item.
	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic              rx_is_ack;
		logic [ID_W-1:0]   rx_packet_id;
		logic [NODE_W-1:0] rx_source_id;
		logic [TTL_W-1:0]  rx_ttl;
		logic [HOPS_W-1:0] rx_hops;
	} item_t;

	// One result item.
	typedef struct packed {
		kind_t             kind;
		logic              is_ack;
		logic [ID_W-1:0]   packet_id;
		logic [NODE_W-1:0] source_id;
		logic [TTL_W-1:0]  ttl;
		logic [HOPS_W-1:0] hops;
		logic              last;
	} result_t;

	// Results of one item as handed to the queue.
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

	function automatic result_t mk_result(
		input kind_t             kind,
		input logic              is_ack,
		input logic [ID_W-1:0]   packet_id,
		input logic [NODE_W-1:0] source_id,
		input logic [TTL_W-1:0]  ttl,
		input logic [HOPS_W-1:0] hops,
		input logic              last
	);
		result_t r;
		r.kind      = kind;
		r.is_ack    = is_ack;
		r.packet_id = packet_id;
		r.source_id = source_id;
		r.ttl       = ttl;
		r.hops      = hops;
		r.last      = last;
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/marf_engine.sv @@
// Header engine: configuration registers, protocol state and the decision logic
// for one item. Depends on marf_pkg.
`default_nettype none

module marf_engine (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [marf_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [marf_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                                fire,
	input  wire marf_pkg::item_t                     item,
	output marf_pkg::push_t                          push
);

	// Configuration registers.
	logic [marf_pkg::NODE_W-1:0] node_id_q;
	logic [marf_pkg::TTL_W-1:0]  default_ttl_q;
	logic [7:0]                  max_retry_q;
	logic [marf_pkg::TIME_W-1:0] ack_timeout_q;

	// Protocol state.
	logic [marf_pkg::ID_W-1:0]   seq_q, seq_d;
	logic [marf_pkg::ID_W-1:0]   pend_id_q, pend_id_d;
	logic [marf_pkg::TTL_W-1:0]  pend_ttl_q, pend_ttl_d;
	logic                        awaiting_q, awaiting_d;
	logic [7:0]                  resend_q, resend_d;
	logic [marf_pkg::TIME_W-1:0] elapsed_q, elapsed_d;

	logic [marf_pkg::ID_W-1:0]   seq_inc;
	logic [marf_pkg::TIME_W-1:0] elapsed_inc;
	logic [marf_pkg::HOPS_W-1:0] hops_inc;

	// Register writes from the configuration channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q     <= marf_pkg::NODE_ID_RST;
			default_ttl_q <= marf_pkg::DEFAULT_TTL_RST;
			max_retry_q   <= marf_pkg::MAX_RETRY_RST;
			ack_timeout_q <= marf_pkg::ACK_TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				marf_pkg::CFG_NODE_ID:     node_id_q     <= cfg_data[marf_pkg::NODE_W-1:0];
				marf_pkg::CFG_DEFAULT_TTL: default_ttl_q <= cfg_data[marf_pkg::TTL_W-1:0];
				marf_pkg::CFG_MAX_RETRY:   max_retry_q   <= cfg_data[7:0];
				marf_pkg::CFG_ACK_TIMEOUT: ack_timeout_q <= cfg_data[marf_pkg::TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// Incremented values: wrapping counter, saturating timer and hop count.
	assign seq_inc     = seq_q + 32'd1;
	assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + 32'd1;
	assign hops_inc    = (&item.rx_hops) ? item.rx_hops : item.rx_hops + 8'd1;

	// Decision for the item in the input register and the state it leaves.
	always_comb begin
		seq_d      = seq_q;
		pend_id_d  = pend_id_q;
		pend_ttl_d = pend_ttl_q;
		awaiting_d = awaiting_q;
		resend_d   = resend_q;
		elapsed_d  = elapsed_q;
		push.count  = 2'd0;
		push.first  = marf_pkg::mk_result(marf_pkg::KIND_NEW, 1'b0, '0, '0, '0, '0, 1'b1);
		push.second = marf_pkg::mk_result(marf_pkg::KIND_FWD, 1'b0, item.rx_packet_id,
			item.rx_source_id, item.rx_ttl - 8'd1, hops_inc, 1'b1);
		unique case (item.req_type)
			marf_pkg::REQ_SEND: begin
				seq_d      = seq_inc;
				pend_id_d  = seq_inc;
				pend_ttl_d = default_ttl_q;
				awaiting_d = 1'b1;
				resend_d   = 8'd0;
				elapsed_d  = '0;
				push.count = 2'd1;
				push.first = marf_pkg::mk_result(marf_pkg::KIND_NEW, 1'b0, seq_inc,
					node_id_q, default_ttl_q, '0, 1'b1);
			end
			marf_pkg::REQ_RX: begin
				if (item.rx_is_ack) begin
					// Only an ack for the kept packet while waiting counts.
					if (awaiting_q && (item.rx_packet_id == pend_id_q)) begin
						awaiting_d = 1'b0;
						push.count = 2'd1;
						push.first = marf_pkg::mk_result(marf_pkg::KIND_MATCHED, 1'b0,
							item.rx_packet_id, '0, '0, '0, 1'b1);
					end
				end else if (item.rx_source_id != node_id_q) begin
					if (item.rx_ttl == '0) begin
						push.count = 2'd1;
						push.first = marf_pkg::mk_result(marf_pkg::KIND_DROP, 1'b0,
							item.rx_packet_id, '0, '0, '0, 1'b1);
					end else begin
						// Ack first, then the forwarded copy.
						push.count = 2'd2;
						push.first = marf_pkg::mk_result(marf_pkg::KIND_ACK, 1'b1,
							item.rx_packet_id, node_id_q, marf_pkg::ACK_TTL, '0, 1'b0);
					end
				end
			end
			marf_pkg::REQ_TICK: begin
				elapsed_d = elapsed_inc;
				if (awaiting_q && (elapsed_inc >= ack_timeout_q)) begin
					push.count = 2'd1;
					if (resend_q >= max_retry_q) begin
						awaiting_d = 1'b0;
						push.first = marf_pkg::mk_result(marf_pkg::KIND_FAILED, 1'b0,
							pend_id_q, '0, '0, '0, 1'b1);
					end else begin
						resend_d   = resend_q + 8'd1;
						elapsed_d  = '0;
						push.first = marf_pkg::mk_result(marf_pkg::KIND_RETRY, 1'b0,
							pend_id_q, node_id_q, pend_ttl_q, '0, 1'b1);
					end
				end
			end
			default: ;
		endcase
		// Nothing is queued unless the item is actually processed.
		if (!fire) begin
			push.count = 2'd0;
		end
	end

	// State update when the item leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q      <= '0;
			pend_id_q  <= '0;
			pend_ttl_q <= '0;
			awaiting_q <= 1'b0;
			resend_q   <= '0;
			elapsed_q  <= '0;
		end else if (fire) begin
			seq_q      <= seq_d;
			pend_id_q  <= pend_id_d;
			pend_ttl_q <= pend_ttl_d;
			awaiting_q <= awaiting_d;
			resend_q   <= resend_d;
			elapsed_q  <= elapsed_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/marf_out_fifo.sv @@
// Result queue: takes up to two results per cycle, gives one per beat.
// Depends on marf_pkg.
`default_nettype none

module marf_out_fifo #(
	parameter int DEPTH = marf_pkg::FIFO_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire marf_pkg::push_t  push,
	output logic                  room,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output marf_pkg::result_t     out_result
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] ROOM_LIMIT = CW'(DEPTH - 2);

	marf_pkg::result_t entry_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          pop;

	// Two free entries are needed before another item may be processed.
	assign room       = (count_q <= ROOM_LIMIT);
	assign out_valid  = (count_q != '0);
	assign out_result = entry_q[rd_ptr_q];
	assign pop        = out_valid && out_ready;

	// Entry writes.
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			entry_q[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			entry_q[wr_ptr_q + AW'(1)] <= push.second;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + AW'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			count_q <= count_q + CW'(push.count) - CW'(pop);
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/mesh_ack_retry_forwarder.sv @@
// Top level of the mesh ack/retry forwarder: input register, header engine and
// result queue. Depends on marf_pkg, marf_engine and marf_out_fifo.
//
//   channel  direction  handshake              payload
//   s_*      in         s_tvalid / s_tready    tdata header, tuser request selectors
//   m_*      out        m_tvalid / m_tready    tdata header, tuser kind, tlast
//   cfg_*    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An input beat lands in the input register and is decided there once the result
// queue has two free entries, which writes its zero, one or two results into the
// result queue; one item per cycle is taken while the queue has two free entries,
// and results leave at one beat per cycle while m_tready is high.
// Reset clears all protocol state and restores the register defaults.
// cfg_ready is always high.
`default_nettype none

module mesh_ack_retry_forwarder #(
	parameter int FIFO_DEPTH = marf_pkg::FIFO_DEPTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// rx_packet_id[31:0], rx_source_id[39:32], rx_ttl[47:40], rx_hops[55:48]
	input  wire logic [marf_pkg::IN_TDATA_W-1:0]    s_tdata,
	// req_type[1:0], rx_is_ack[2]
	input  wire logic [marf_pkg::IN_TUSER_W-1:0]    s_tuser,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// out_packet_id[31:0], out_source_id[39:32], out_ttl[47:40], out_hops[55:48]
	output logic [marf_pkg::OUT_TDATA_W-1:0]        m_tdata,
	// out_kind[2:0], out_is_ack[3]
	output logic [marf_pkg::OUT_TUSER_W-1:0]        m_tuser,
	output logic                                    m_tlast,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [marf_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [marf_pkg::CFG_DATA_W-1:0]    cfg_data
);

	logic              item_valid_s1;
	marf_pkg::item_t   item_s1;
	logic              room;
	logic              fire;
	marf_pkg::push_t   push;
	marf_pkg::result_t res;

	assign cfg_ready = 1'b1;
	assign fire      = item_valid_s1 && room;
	assign s_tready  = !item_valid_s1 || room;

	// Input register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			item_valid_s1 <= s_tvalid;
		end
	end

	// Input register payload, unpacked from the stream.
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.req_type     <= s_tuser[1:0];
			item_s1.rx_is_ack    <= s_tuser[2];
			item_s1.rx_packet_id <= s_tdata[31:0];
			item_s1.rx_source_id <= s_tdata[39:32];
			item_s1.rx_ttl       <= s_tdata[47:40];
			item_s1.rx_hops      <= s_tdata[55:48];
		end
	end

	marf_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fire      (fire),
		.item      (item_s1),
		.push      (push)
	);

	marf_out_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_out_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.room       (room),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_result (res)
	);

	// Pack the head result onto the stream.
	assign m_tdata = {res.hops, res.ttl, res.source_id, res.packet_id};
	assign m_tuser = {res.is_ack, res.kind};
	assign m_tlast = res.last;

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for the mesh ack/retry forwarder header engine.
// Depends on marf_pkg and the mesh_ack_retry_forwarder RTL; a scoreboard class
// predicts every result header and checks the output stream in order.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import marf_pkg::*;

	// Request code that the block ignores.
	localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;
	// Cycles with no beat on any channel before the run is declared hung.
	localparam int IDLE_LIMIT = 2000;
	// Cycles that let an item with no result leave the pipeline.
	localparam int PIPE_SETTLE = 4;
	localparam int PHASES = 10;
	localparam int ITEMS_PER_PHASE = 130;

	// Tracks the protocol state of the node and holds the headers still due.
	class forwarder_tracker;
		logic [NODE_W-1:0] my_node;
		logic [TTL_W-1:0]  send_ttl;
		logic [7:0]        retry_limit;
		logic [TIME_W-1:0] timeout_ticks;

		logic [ID_W-1:0]   seq_num;
		logic [ID_W-1:0]   wait_id;
		logic [TTL_W-1:0]  wait_ttl;
		logic              waiting;
		logic [7:0]        resends;
		logic [TIME_W-1:0] timer;

		result_t due_headers[$];
		int mismatches;

		function void clear();
			my_node = NODE_ID_RST;
			send_ttl = DEFAULT_TTL_RST;
			retry_limit = MAX_RETRY_RST;
			timeout_ticks = ACK_TIMEOUT_RST;
			seq_num = '0;
			wait_id = '0;
			wait_ttl = '0;
			waiting = 1'b0;
			resends = '0;
			timer = '0;
			due_headers.delete();
			mismatches = 0;
		endfunction

		function void set_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
			case (index)
				CFG_NODE_ID: my_node = value[NODE_W-1:0];
				CFG_DEFAULT_TTL: send_ttl = value[TTL_W-1:0];
				CFG_MAX_RETRY: retry_limit = value[7:0];
				CFG_ACK_TIMEOUT: timeout_ticks = value[TIME_W-1:0];
				default: ;
			endcase
		endfunction

		function void due(kind_t kind, logic is_ack, logic [ID_W-1:0] id,
				logic [NODE_W-1:0] src, logic [TTL_W-1:0] ttl, logic [HOPS_W-1:0] hops,
				logic last);
			result_t r;
			r.kind = kind;
			r.is_ack = is_ack;
			r.packet_id = id;
			r.source_id = src;
			r.ttl = ttl;
			r.hops = hops;
			r.last = last;
			due_headers.push_back(r);
		endfunction

		// Advance the node state by one accepted request beat.
		function void accept_request(item_t it);
			case (it.req_type)
				REQ_SEND: begin
					seq_num = seq_num + 32'd1;
					wait_id = seq_num;
					wait_ttl = send_ttl;
					waiting = 1'b1;
					resends = '0;
					timer = '0;
					due(KIND_NEW, 1'b0, wait_id, my_node, wait_ttl, '0, 1'b1);
				end
				REQ_RX: begin
					if (it.rx_is_ack) begin
						// Only the ack for the packet being waited on counts.
						if (waiting && it.rx_packet_id == wait_id) begin
							waiting = 1'b0;
							due(KIND_MATCHED, 1'b0, it.rx_packet_id, '0, '0, '0, 1'b1);
						end
					end else if (it.rx_source_id == my_node) begin
						// Our own packet came back around: dropped silently.
					end else if (it.rx_ttl == '0) begin
						due(KIND_DROP, 1'b0, it.rx_packet_id, '0, '0, '0, 1'b1);
					end else begin
						due(KIND_ACK, 1'b1, it.rx_packet_id, my_node, ACK_TTL, '0, 1'b0);
						due(KIND_FWD, 1'b0, it.rx_packet_id, it.rx_source_id, it.rx_ttl - 1'b1,
							(it.rx_hops == '1) ? it.rx_hops : it.rx_hops + 1'b1, 1'b1);
					end
				end
				REQ_TICK: begin
					if (timer != '1)
						timer = timer + 32'd1;
					if (waiting && timer >= timeout_ticks) begin
						if (resends >= retry_limit) begin
							waiting = 1'b0;
							due(KIND_FAILED, 1'b0, wait_id, '0, '0, '0, 1'b1);
						end else begin
							resends = resends + 8'd1;
							timer = '0;
							due(KIND_RETRY, 1'b0, wait_id, my_node, wait_ttl, '0, 1'b1);
						end
					end
				end
				default: ;
			endcase
		endfunction

		function string show(result_t r);
			return $sformatf("kind=%0d is_ack=%0b id=%08h src=%02h ttl=%02h hops=%02h last=%0b",
				r.kind, r.is_ack, r.packet_id, r.source_id, r.ttl, r.hops, r.last);
		endfunction

		// Compare one output beat with the oldest header still due.
		function void check_header(result_t got);
			result_t want;
			if (due_headers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result beat: %s", show(got));
				return;
			end
			want = due_headers.pop_front();
			if (got.kind !== want.kind || got.is_ack !== want.is_ack ||
					got.packet_id !== want.packet_id || got.source_id !== want.source_id ||
					got.ttl !== want.ttl || got.hops !== want.hops || got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("ERROR: result mismatch at %0t", $realtime);
					$display("  expected: %s", show(want));
					$display("  actual:   %s", show(got));
				end
			end
		endfunction

		function int outstanding();
			return due_headers.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata;
	logic [IN_TUSER_W-1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [OUT_TUSER_W-1:0] m_tuser;
	logic m_tlast;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	forwarder_tracker trk;
	// When set, neither side idles.
	bit calm;
	int idle_cycles;

	mesh_ack_retry_forwarder u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic item_t build(logic [REQ_W-1:0] req, logic is_ack, logic [ID_W-1:0] id,
			logic [NODE_W-1:0] src, logic [TTL_W-1:0] ttl, logic [HOPS_W-1:0] hops);
		item_t it;
		it.req_type = req;
		it.rx_is_ack = is_ack;
		it.rx_packet_id = id;
		it.rx_source_id = src;
		it.rx_ttl = ttl;
		it.rx_hops = hops;
		return it;
	endfunction

	// Random request, weighted toward sequences that reach acks, resends and failures.
	function automatic item_t random_request();
		item_t it;
		int r;
		int shape;
		r = $urandom_range(0, 99);
		shape = $urandom_range(0, 9);
		it = build(REQ_RX, 1'($urandom_range(0, 1)), $urandom, 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		if (r < 18) begin
			it.req_type = REQ_SEND;
		end else if (r < 52) begin
			it.req_type = REQ_TICK;
		end else if (r < 71) begin
			// Acks: mostly the awaited id, some one bit off, some anything.
			it.rx_is_ack = 1'b1;
			if (r < 64)
				it.rx_packet_id = trk.wait_id;
			else if (r < 68)
				it.rx_packet_id = trk.wait_id ^ (32'd1 << $urandom_range(0, 31));
		end else if (r < 97) begin
			it.rx_is_ack = 1'b0;
			if (it.rx_source_id == trk.my_node)
				it.rx_source_id = it.rx_source_id + 1'b1;
			if (shape == 0)
				it.rx_ttl = 8'd1;
			else if (shape == 1)
				it.rx_ttl = 8'hFF;
			else
				it.rx_ttl = 8'($urandom_range(1, 255));
			if (shape == 2)
				it.rx_hops = 8'hFF;
			else if (shape == 3)
				it.rx_hops = 8'hFE;
			if (r >= 89 && r < 93)
				it.rx_source_id = trk.my_node;
			else if (r >= 93)
				it.rx_ttl = '0;
		end else begin
			it.req_type = REQ_SPARE;
		end
		return it;
	endfunction

	// Offer one request beat and note it once accepted.
	task automatic push_request(input item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {it.rx_hops, it.rx_ttl, it.rx_source_id, it.rx_packet_id};
		s_tuser <= {it.rx_is_ack, it.req_type};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		trk.accept_request(it);
	endtask

	// Stop offering and wait until every due header has come out.
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (trk.outstanding() != 0)
			@(posedge clk);
		repeat (PIPE_SETTLE) @(posedge clk);
	endtask

	// Write all four registers back to back; only called while the block is idle.
	task automatic program_regs(input logic [7:0] node, input logic [7:0] ttl,
			input logic [7:0] retry, input logic [31:0] timeout);
		logic [CFG_INDEX_W-1:0] idx [4];
		logic [CFG_DATA_W-1:0] val [4];
		idx[0] = CFG_NODE_ID;
		idx[1] = CFG_DEFAULT_TTL;
		idx[2] = CFG_MAX_RETRY;
		idx[3] = CFG_ACK_TIMEOUT;
		val[0] = {24'd0, node};
		val[1] = {24'd0, ttl};
		val[2] = {24'd0, retry};
		val[3] = timeout;
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			trk.set_register(idx[i], val[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	// Result sink with random back-pressure.
	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = pick_gap();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	// Check every result beat as it is taken.
	always @(posedge clk) begin
		result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind = kind_t'(m_tuser[2:0]);
			got.is_ack = m_tuser[3];
			got.packet_id = m_tdata[31:0];
			got.source_id = m_tdata[39:32];
			got.ttl = m_tdata[47:40];
			got.hops = m_tdata[55:48];
			got.last = m_tlast;
			trk.check_header(got);
		end
	end

	// Hang detection: count cycles in which no channel moves a beat.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("mesh_ack_retry_forwarder regression: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int counted;
		item_t it;
		trk = new;
		trk.clear();
		calm = 1'b0;
		idle_cycles = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with the reset register values.
		push_request(build(REQ_SEND, 1'b0, '0, '0, '0, '0));
		push_request(build(REQ_RX, 1'b1, 32'd2, 8'd9, 8'd1, 8'd0));
		push_request(build(REQ_RX, 1'b1, 32'd1, 8'd9, 8'd1, 8'd0));
		push_request(build(REQ_RX, 1'b1, 32'd1, 8'd9, 8'd1, 8'd0));
		push_request(build(REQ_RX, 1'b0, 32'h1234_5678, 8'h00, 8'd5, 8'd2));
		push_request(build(REQ_RX, 1'b0, 32'hFFFF_FFFF, 8'hFF, 8'h00, 8'h10));
		push_request(build(REQ_RX, 1'b0, 32'h0000_0000, 8'hFF, 8'hFF, 8'hFF));
		push_request(build(REQ_RX, 1'b0, 32'h8000_0001, 8'h01, 8'h01, 8'hFE));
		push_request(build(REQ_SPARE, 1'b1, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF));
		push_request(build(REQ_TICK, 1'b0, '0, '0, '0, '0));
		settle();

		// Zero timeout with no resends: the first tick reports failure.
		program_regs(8'hFF, 8'hFF, 8'd0, 32'd0);
		push_request(build(REQ_SEND, 1'b1, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF));
		push_request(build(REQ_TICK, 1'b1, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF));
		push_request(build(REQ_RX, 1'b0, 32'hA5A5_5A5A, 8'h00, 8'd2, 8'd0));
		push_request(build(REQ_RX, 1'b0, 32'h5A5A_A5A5, 8'hFF, 8'd2, 8'd0));
		settle();

		// A resend carries the node id in force at the time of the resend.
		program_regs(8'h42, 8'h00, 8'd1, 32'd1);
		push_request(build(REQ_SEND, 1'b0, '0, '0, '0, '0));
		settle();
		program_regs(8'h24, 8'h00, 8'd1, 32'd1);
		push_request(build(REQ_TICK, 1'b0, '0, '0, '0, '0));
		push_request(build(REQ_TICK, 1'b0, '0, '0, '0, '0));
		push_request(build(REQ_TICK, 1'b0, '0, '0, '0, '0));
		settle();

		// Ack arriving after one resend.
		program_regs(8'h24, 8'd7, 8'd2, 32'd2);
		push_request(build(REQ_SEND, 1'b0, '0, '0, '0, '0));
		push_request(build(REQ_TICK, 1'b0, '0, '0, '0, '0));
		push_request(build(REQ_TICK, 1'b0, '0, '0, '0, '0));
		push_request(build(REQ_RX, 1'b1, trk.wait_id, 8'h24, 8'd1, 8'd0));
		settle();

		// Random phases across register settings and idling patterns.
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: program_regs(8'h5A, 8'd8, 8'd2, 32'd3);
				1: program_regs(8'h00, 8'd0, 8'd0, 32'd1);
				2: program_regs(8'hFF, 8'hFF, 8'hFF, 32'd1);
				3: program_regs(8'h13, 8'd1, 8'd1, 32'd2);
				4: program_regs(8'hA7, 8'd64, 8'd4, 32'd5);
				5: program_regs(8'h3C, 8'd200, 8'd3, 32'd2000);
				6: program_regs(8'h81, 8'd2, 8'd2, 32'hFFFF_FFFF);
				7: program_regs(8'h00, 8'hFF, 8'd1, 32'd4);
				default: program_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 4)), 32'($urandom_range(1, 6)));
			endcase
			calm = (ph % 4 == 1);
			counted = 0;
			while (counted < ITEMS_PER_PHASE) begin
				it = random_request();
				push_request(it);
				if (it.req_type != REQ_SPARE)
					counted++;
			end
			settle();
		end

		repeat (2 * PIPE_SETTLE) @(posedge clk);
		if (trk.mismatches == 0 && trk.outstanding() == 0)
			$display("mesh_ack_retry_forwarder regression: pass");
		else
			$display("mesh_ack_retry_forwarder regression: fail");
		$finish;
	end

endmodule

@@ mesh_ack_retry_forwarder.f @@
rtl/core/marf_pkg.sv
rtl/core/marf_engine.sv
rtl/core/marf_out_fifo.sv
rtl/core/mesh_ack_retry_forwarder.sv
dv/testbench.sv
